// ----- src/mpm_pkg.sv -----
// Package for the multi-pattern matcher: sizes, input kinds, status codes.
// Used by multi_pattern_matcher_unit, mpm_checker and tb.
package mpm_pkg;
    localparam int MaxNodes   = 1024;
    localparam int Alphabet   = 26;
    localparam int CountWidth = 32;
    localparam int NodeW      = $clog2(MaxNodes);
    localparam int UsedW      = $clog2(MaxNodes + 1);
    localparam int LetterW    = 5;
    localparam int SlotW      = $clog2(MaxNodes * Alphabet);
    localparam int MatchW     = UsedW;
    localparam int ClearLen   = MaxNodes * Alphabet;

    localparam logic [2:0] KIND_PLETTER = 3'd0;
    localparam logic [2:0] KIND_PEND    = 3'd1;
    localparam logic [2:0] KIND_BUILD   = 3'd2;
    localparam logic [2:0] KIND_TLETTER = 3'd3;
    localparam logic [2:0] KIND_TEND    = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_NOLINKS = 2'd3;

    typedef logic [NodeW-1:0] t_node;

    function automatic logic [SlotW-1:0] slot_of(input t_node n, input logic [LetterW-1:0] c);
        logic [SlotW+LetterW-1:0] s;
        s = SlotW'(n) * SlotW'(Alphabet) + (SlotW+LetterW)'(c);
        return s[SlotW-1:0];
    endfunction
endpackage

// ----- src/mpm_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module mpm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/multi_pattern_matcher_unit.sv -----
// Aho-Corasick matcher: trie, failure links and match counts in RAMs; uses mpm_pkg, mpm_ram.
// Pattern letters walk or extend the trie; text letters follow failure links until a child
// exists and add its match count; build scans each queued node's child slots breadth-first.
// Range errors, no links, text end and unused kinds go straight to the output state.
// One request at a time; the result register frees the input while a result waits.
// Reset: a clearing pass over all 26624 child slots zeroes child, fail and end tables; stall until done.
module multi_pattern_matcher_unit
    import mpm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [2:0]   i_kind,
    input  logic [4:0]   i_letter,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [31:0]  o_match_count,
    output logic [1:0]   o_status
);
    localparam logic [4:0] S_CLEAR = 5'd0, S_IDLE = 5'd1, S_PL = 5'd2, S_PE = 5'd3,
        S_TL_RD = 5'd4, S_TL_FL = 5'd5, S_TL_NM = 5'd6, S_B_INIT = 5'd7,
        S_B_CH = 5'd8, S_B_FL = 5'd9, S_B_VC = 5'd10, S_B_NM = 5'd11,
        S_B_WR = 5'd12, S_B_POP = 5'd13, S_OUT = 5'd14, S_TL_ADD = 5'd15,
        S_B_LOAD = 5'd16;

    logic [4:0] r_state, n_state;
    logic [SlotW-1:0] r_clr;
    logic [UsedW-1:0] r_used;
    t_node r_cur, r_scan, r_t, r_v, r_ch;
    logic [CountWidth-1:0] r_total;
    logic r_ready;
    logic [LetterW-1:0] r_letter, r_c;
    logic [UsedW-1:0] r_head, r_tail;
    logic r_endm;
    logic [31:0] r_res_cnt, r_out_cnt;
    logic [1:0] r_res_st, r_out_st;
    logic r_ovalid;

    // memories
    logic ct_we; logic [SlotW-1:0] ct_wa, ct_ra; t_node ct_wd, ct_rd;
    logic fl_we; t_node fl_wa, fl_ra, fl_wd, fl_rd;
    logic em_we; t_node em_wa, em_ra; logic em_wd, em_rd;
    logic nm_we; t_node nm_wa, nm_ra; logic [MatchW-1:0] nm_wd, nm_rd;
    logic bq_we; t_node bq_wa, bq_ra, bq_wd, bq_rd;

    mpm_ram #(.Width(NodeW), .Depth(MaxNodes*Alphabet)) u_child (.i_clk, .i_we(ct_we),
        .i_waddr(ct_wa), .i_wdata(ct_wd), .i_raddr(ct_ra), .o_rdata(ct_rd));
    mpm_ram #(.Width(NodeW), .Depth(MaxNodes)) u_fail (.i_clk, .i_we(fl_we),
        .i_waddr(fl_wa), .i_wdata(fl_wd), .i_raddr(fl_ra), .o_rdata(fl_rd));
    mpm_ram #(.Width(1), .Depth(MaxNodes)) u_end (.i_clk, .i_we(em_we),
        .i_waddr(em_wa), .i_wdata(em_wd), .i_raddr(em_ra), .o_rdata(em_rd));
    mpm_ram #(.Width(MatchW), .Depth(MaxNodes)) u_nm (.i_clk, .i_we(nm_we),
        .i_waddr(nm_wa), .i_wdata(nm_wd), .i_raddr(nm_ra), .o_rdata(nm_rd));
    mpm_ram #(.Width(NodeW), .Depth(MaxNodes)) u_bq (.i_clk, .i_we(bq_we),
        .i_waddr(bq_wa), .i_wdata(bq_wd), .i_raddr(bq_ra), .o_rdata(bq_rd));

    logic in_acc, out_acc, load_out;
    assign o_stall = !(r_state == S_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_ovalid && !i_stall;
    assign load_out = (r_state == S_OUT) && (!r_ovalid || !i_stall);
    assign o_valid = r_ovalid;
    assign o_match_count = r_out_cnt;
    assign o_status = r_out_st;

    logic [CountWidth:0] sum;
    assign sum = {1'b0, r_total} + (CountWidth+1)'(nm_rd);
    logic [MatchW:0] bsum;
    assign bsum = (MatchW+1)'(nm_rd) + (MatchW+1)'(r_endm);

    logic [NodeW-1:0] clr_node;
    assign clr_node = r_clr[NodeW-1:0];

    always_comb begin
        n_state = r_state;
        ct_we = 1'b0; ct_wa = '0; ct_wd = '0; ct_ra = '0;
        fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_ra = '0;
        em_we = 1'b0; em_wa = '0; em_wd = 1'b0; em_ra = '0;
        nm_we = 1'b0; nm_wa = '0; nm_wd = '0; nm_ra = '0;
        bq_we = 1'b0; bq_wa = '0; bq_wd = '0; bq_ra = '0;
        unique case (r_state)
            S_CLEAR: begin
                ct_we = 1'b1; ct_wa = r_clr;
                if (r_clr < SlotW'(MaxNodes)) begin
                    fl_we = 1'b1; fl_wa = clr_node;
                    em_we = 1'b1; em_wa = clr_node;
                end
            end
            S_IDLE: begin
                ct_ra = slot_of(r_cur, i_letter);
                if (i_kind == KIND_TLETTER) begin
                    ct_ra = slot_of(r_scan, i_letter);
                end
                fl_ra = r_scan;
                nm_ra = '0;
                ct_ra = (i_kind == KIND_BUILD) ? slot_of('0, '0) : ct_ra;
                em_ra = '0;
            end
            S_PL: begin
                if (ct_rd == '0 && r_used < UsedW'(MaxNodes)) begin
                    ct_we = 1'b1; ct_wa = slot_of(r_cur, r_letter);
                    ct_wd = r_used[NodeW-1:0];
                end
            end
            S_PE: begin
                em_we = 1'b1; em_wa = r_cur; em_wd = 1'b1;
            end
            S_TL_RD: begin
                // ct_rd = child(s, c), fl_rd = fail(s)
                if (ct_rd != '0 || r_v == '0) begin
                    nm_ra = ct_rd;
                end else begin
                    ct_ra = slot_of(fl_rd, r_letter);
                    fl_ra = fl_rd;
                end
            end
            S_TL_FL: begin
                // hold the read of the new node so TL_RD sees it
                ct_ra = slot_of(r_v, r_letter);
                fl_ra = r_v;
            end
            S_TL_NM: begin
                nm_ra = r_scan;
            end
            S_TL_ADD: ;
            S_B_INIT: begin
                // root: node_matches = end_mark(0)
                nm_we = 1'b1; nm_wa = '0; nm_wd = MatchW'(em_rd);
                fl_we = 1'b1; fl_wa = '0;
                bq_ra = '0;
            end
            S_B_CH: begin
                // ct_rd = child(t, c); fl_rd = fail(t)
                if (ct_rd != '0) begin
                    em_ra = ct_rd;
                    if (r_t == '0) begin
                        nm_ra = '0;
                    end else begin
                        ct_ra = slot_of(fl_rd, r_c);
                        fl_ra = fl_rd;
                    end
                end else begin
                    ct_ra = slot_of(r_t, r_c + 1'b1);
                    fl_ra = r_t;
                end
            end
            S_B_FL: ;
            S_B_VC: begin
                // ct_rd = child(v, c), fl_rd = fail(v)
                em_ra = r_ch;
                if (ct_rd != '0 || r_v == '0) begin
                    nm_ra = ct_rd;
                end else begin
                    ct_ra = slot_of(fl_rd, r_c);
                    fl_ra = fl_rd;
                end
            end
            S_B_NM: begin
                nm_we = 1'b1; nm_wa = r_ch; nm_wd = bsum[MatchW-1:0];
                fl_we = 1'b1; fl_wa = r_ch; fl_wd = r_v;
                if (r_tail < UsedW'(MaxNodes)) begin
                    bq_we = 1'b1; bq_wa = r_tail[NodeW-1:0]; bq_wd = r_ch;
                end
            end
            S_B_WR: begin
                ct_ra = slot_of(r_t, r_c);
                fl_ra = r_t;
            end
            S_B_POP: begin
                bq_ra = r_head[NodeW-1:0];
            end
            S_B_LOAD: ;
            S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0; r_used <= UsedW'(1);
            r_cur <= '0; r_scan <= '0; r_total <= '0; r_ready <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (load_out) begin
                r_ovalid <= 1'b1; r_out_cnt <= r_res_cnt; r_out_st <= r_res_st;
            end else if (out_acc) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SlotW'(ClearLen - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (in_acc) begin
                    r_letter <= i_letter;
                    r_res_cnt <= 32'(r_total);
                    r_res_st <= ST_OK;
                    r_v <= r_scan;
                    priority if ((i_kind == KIND_PLETTER || i_kind == KIND_TLETTER)
                                 && i_letter >= LetterW'(Alphabet)) begin
                        r_res_st <= ST_RANGE; r_state <= S_OUT;
                    end else if (i_kind == KIND_PLETTER) begin
                        r_ready <= 1'b0; r_state <= S_PL;
                    end else if (i_kind == KIND_PEND) begin
                        r_ready <= 1'b0; r_state <= S_PE;
                    end else if (i_kind == KIND_BUILD) begin
                        r_state <= S_B_INIT;
                    end else if (i_kind == KIND_TLETTER) begin
                        if (!r_ready) begin
                            r_res_st <= ST_NOLINKS; r_state <= S_OUT;
                        end else begin
                            r_state <= S_TL_RD;
                        end
                    end else if (i_kind == KIND_TEND) begin
                        if (!r_ready) r_res_st <= ST_NOLINKS;
                        r_total <= '0; r_scan <= '0; r_state <= S_OUT;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_PL: begin
                    if (ct_rd != '0) begin
                        r_cur <= ct_rd;
                    end else if (r_used >= UsedW'(MaxNodes)) begin
                        r_res_st <= ST_FULL;
                    end else begin
                        r_cur <= r_used[NodeW-1:0];
                        r_used <= r_used + 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_PE: begin
                    r_cur <= '0; r_state <= S_OUT;
                end
                S_TL_RD: begin
                    if (ct_rd != '0 || r_v == '0) begin
                        r_scan <= ct_rd; r_state <= S_TL_NM;
                    end else begin
                        r_v <= fl_rd; r_state <= S_TL_FL;
                    end
                end
                S_TL_FL: r_state <= S_TL_RD;
                S_TL_NM: r_state <= S_TL_ADD;
                S_TL_ADD: begin
                    if (sum[CountWidth]) begin
                        r_total <= '1; r_res_cnt <= 32'({CountWidth{1'b1}});
                    end else begin
                        r_total <= sum[CountWidth-1:0];
                        r_res_cnt <= 32'(sum[CountWidth-1:0]);
                    end
                    r_state <= S_OUT;
                end
                S_B_INIT: begin
                    // children of root are processed as node t=0 with fail 0
                    r_t <= '0; r_c <= '0; r_head <= '0; r_tail <= '0;
                    r_state <= S_B_WR;
                end
                S_B_WR: r_state <= S_B_CH;
                S_B_CH: begin
                    if (ct_rd != '0) begin
                        r_ch <= ct_rd;
                        if (r_t == '0) begin
                            r_v <= '0; r_state <= S_B_FL;
                        end else begin
                            r_v <= fl_rd; r_state <= S_B_VC;
                        end
                    end else if (r_c == LetterW'(Alphabet - 1)) begin
                        r_state <= S_B_POP;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                S_B_FL: begin
                    // root child: fail 0, count from root
                    r_endm <= em_rd; r_state <= S_B_NM;
                end
                S_B_VC: begin
                    if (ct_rd != '0 || r_v == '0) begin
                        r_v <= ct_rd; r_endm <= em_rd; r_state <= S_B_NM;
                    end else begin
                        r_v <= fl_rd;
                    end
                end
                S_B_NM: begin
                    if (r_tail < UsedW'(MaxNodes)) r_tail <= r_tail + 1'b1;
                    if (r_c == LetterW'(Alphabet - 1)) begin
                        r_state <= S_B_POP;
                    end else begin
                        r_c <= r_c + 1'b1; r_state <= S_B_WR;
                    end
                end
                S_B_POP: begin
                    if (r_head == r_tail) begin
                        r_ready <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_head <= r_head + 1'b1; r_c <= '0;
                        r_state <= S_B_LOAD;
                    end
                end
                S_B_LOAD: begin
                    r_t <= bq_rd; r_state <= S_B_WR;
                end
                S_OUT: begin
                    if (load_out) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_match_count) && $stable(o_status));
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> o_stall);
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used != '0 && r_used <= UsedW'(MaxNodes));
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_B_POP |-> r_head <= r_tail);
endmodule

// ----- tb/mpm_checker.sv -----
// Checker for multi_pattern_matcher_unit: watches both channels and predicts each result
// from its own Aho-Corasick model, then compares count and status in order.
// Depends on mpm_pkg.
`timescale 1ns / 100ps
module mpm_checker
    import mpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_kind,
    input  logic [4:0]  i_letter,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_match_count,
    input  logic [1:0]  i_status,
    output int          o_errors,
    output int          o_pending
);
    typedef struct packed {
        logic [31:0] count;
        logic [1:0]  status;
    } t_result;

    localparam logic [CountWidth-1:0] CountMax = '1;

    int unsigned        trie_child [MaxNodes*Alphabet];
    int unsigned        fail_of [MaxNodes];
    bit                 end_of [MaxNodes];
    int unsigned        hits_of [MaxNodes];
    int unsigned        bfs_q [MaxNodes];
    int unsigned        used_cnt, cursor, scan_at;
    logic [CountWidth-1:0] total;
    bit                 linked;
    t_result            expected_q[$];

    function automatic void clear_model();
        foreach (trie_child[i]) trie_child[i] = 0;
        foreach (fail_of[i]) begin
            fail_of[i] = 0;
            end_of[i] = 0;
            hits_of[i] = 0;
        end
        used_cnt = 1;
        cursor = 0;
        scan_at = 0;
        total = '0;
        linked = 0;
    endfunction

    function automatic void build_links();
        int unsigned head, tail, t, ch, v, f;
        head = 0;
        tail = 0;
        fail_of[0] = 0;
        hits_of[0] = end_of[0];
        for (int c = 0; c < Alphabet; c++) begin
            ch = trie_child[c];
            if (ch != 0 && tail < MaxNodes) begin
                fail_of[ch] = 0;
                hits_of[ch] = end_of[ch] + hits_of[0];
                bfs_q[tail++] = ch;
            end
        end
        while (head < tail) begin
            t = bfs_q[head++];
            for (int c = 0; c < Alphabet; c++) begin
                ch = trie_child[t*Alphabet + c];
                if (ch != 0) begin
                    v = fail_of[t];
                    while (v != 0 && trie_child[v*Alphabet + c] == 0) v = fail_of[v];
                    f = trie_child[v*Alphabet + c];
                    fail_of[ch] = f;
                    hits_of[ch] = end_of[ch] + hits_of[f];
                    if (tail < MaxNodes) bfs_q[tail++] = ch;
                end
            end
        end
        linked = 1;
    endfunction

    function automatic t_result match_step(logic [2:0] kind, logic [4:0] letter);
        t_result r;
        int unsigned s, slot;
        r.status = ST_OK;
        r.count = total[31:0];
        case (kind)
            KIND_PLETTER: begin
                if (letter >= Alphabet) begin
                    r.status = ST_RANGE;
                end else begin
                    linked = 0;
                    slot = cursor*Alphabet + letter;
                    if (trie_child[slot] != 0) begin
                        cursor = trie_child[slot];
                    end else if (used_cnt >= MaxNodes) begin
                        r.status = ST_FULL;
                    end else begin
                        trie_child[slot] = used_cnt;
                        cursor = used_cnt;
                        used_cnt++;
                    end
                end
            end
            KIND_PEND: begin
                end_of[cursor] = 1;
                cursor = 0;
                linked = 0;
            end
            KIND_BUILD: build_links();
            KIND_TLETTER: begin
                if (letter >= Alphabet) begin
                    r.status = ST_RANGE;
                end else if (!linked) begin
                    r.status = ST_NOLINKS;
                end else begin
                    s = scan_at;
                    while (s != 0 && trie_child[s*Alphabet + letter] == 0) s = fail_of[s];
                    s = trie_child[s*Alphabet + letter];
                    scan_at = s;
                    if (CountMax - total < hits_of[s]) total = CountMax;
                    else total = total + hits_of[s];
                    r.count = total[31:0];
                end
            end
            KIND_TEND: begin
                if (!linked) r.status = ST_NOLINKS;
                total = '0;
                scan_at = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        o_errors = 0;
        o_pending = 0;
        clear_model();
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_model();
            expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: result with no request pending: count %0d status %0d",
                                 $realtime, i_match_count, i_status);
                end else begin
                    want = expected_q.pop_front();
                    if (want.count !== i_match_count || want.status !== i_status) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%0t: mismatch: expected count %0d status %0d, got %0d %0d",
                                     $realtime, want.count, want.status,
                                     i_match_count, i_status);
                    end
                end
            end
            if (i_valid && !i_in_stall) expected_q.push_back(match_step(i_kind, i_letter));
        end
        o_pending = expected_q.size();
    end
endmodule

// ----- tb/tb.sv -----
// Testbench top for multi_pattern_matcher_unit: drives pattern, build and text requests
// with random idling on both sides; mpm_checker predicts and compares.
// Depends on mpm_pkg, multi_pattern_matcher_unit, mpm_checker.
`timescale 1ns / 100ps
module tb
    import mpm_pkg::*;
();

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [2:0]  i_kind = KIND_PLETTER;
    logic [4:0]  i_letter = '0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [31:0] o_match_count;
    logic [1:0]  o_status;
    int          errors, pending;
    bit          calm = 0;
    int          stall_left = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    multi_pattern_matcher_unit u_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_kind, .i_letter,
        .o_valid, .i_stall, .o_match_count, .o_status
    );

    mpm_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_kind, .i_letter,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_match_count(o_match_count),
        .i_status(o_status), .o_errors(errors), .o_pending(pending)
    );

    // result side backpressure in bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            i_stall <= 1;
            stall_left = $urandom_range(0, 10);
        end else begin
            i_stall <= 0;
        end
    end

    task automatic send(logic [2:0] kind, logic [4:0] letter);
        bit busy;
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_kind <= kind;
        i_letter <= letter;
        do begin
            @(negedge i_clk);
            busy = o_stall;
            @(posedge i_clk);
        end while (busy);
    endtask

    task automatic send_pattern(int len, int top);
        for (int i = 0; i < len; i++) send(KIND_PLETTER, 5'($urandom_range(0, top)));
        send(KIND_PEND, 5'd0);
    endtask

    task automatic send_text(int len, int top);
        for (int i = 0; i < len; i++) send(KIND_TLETTER, 5'($urandom_range(0, top)));
        send(KIND_TEND, 5'd0);
    endtask

    initial begin
        int sent;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: no links yet, range errors, unused kinds, edge letters
        send(KIND_TLETTER, 5'd0);
        send(KIND_TEND, 5'd0);
        send(KIND_PLETTER, 5'd26);
        send(KIND_PLETTER, 5'd31);
        send(KIND_TLETTER, 5'd31);
        send(3'd5, 5'd21);
        send(3'd6, 5'd10);
        send(3'd7, 5'd31);
        send(KIND_PLETTER, 5'd0);
        send(KIND_PEND, 5'd0);
        send(KIND_PLETTER, 5'd25);
        send(KIND_PLETTER, 5'd0);
        send(KIND_PEND, 5'd0);
        send(KIND_BUILD, 5'd0);
        send(KIND_TLETTER, 5'd25);
        send(KIND_TLETTER, 5'd0);
        send(KIND_TLETTER, 5'd30);
        send(KIND_TEND, 5'd0);
        send(KIND_PEND, 5'd0);          // empty pattern marks the root
        send(KIND_TLETTER, 5'd1);       // links stale after trie change
        send(KIND_BUILD, 5'd0);
        send(KIND_TLETTER, 5'd1);
        send(KIND_BUILD, 5'd0);         // rebuild keeps scan position and total
        send(KIND_TLETTER, 5'd0);
        send(KIND_TEND, 5'd0);

        sent = 25;
        while (sent < 100) begin
            int np, nt, len;
            np = $urandom_range(0, 3);
            for (int p = 0; p < np; p++) begin
                len = $urandom_range(1, 4);
                send_pattern(len, ($urandom_range(0, 7) == 0) ? 25 : 3);
                sent += len + 1;
            end
            if ($urandom_range(0, 9) != 0) begin
                send(KIND_BUILD, 5'd0);
                sent++;
            end
            nt = $urandom_range(2, 5);
            for (int t = 0; t < nt; t++) begin
                len = $urandom_range(1, 20);
                send_text(len, ($urandom_range(0, 3) == 0) ? 31 : 3);
                sent += len + 1;
            end
            if ($urandom_range(0, 3) == 0) begin
                send(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)));
                sent++;
            end
        end

        // last part: no idling; fill the trie until it reports full
        calm = 1;
        send_pattern(1030, 25);
        send(KIND_PLETTER, 5'd9);
        send(KIND_BUILD, 5'd0);
        send_text(40, 25);

        i_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("multi_pattern_matcher_unit test passed");
        end else begin
            $display("multi_pattern_matcher_unit test failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("multi_pattern_matcher_unit test failed");
        $finish;
    end
endmodule
